// File: rtl/enfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enfa_pkg
// Shared types and constants for the epsilon-NFA acceptor: sizes, the layout
// of one transition table entry, item function codes and register indexes.
// ----------------------------------------------------------------------------
package enfa_pkg;

  // automaton sizes
  localparam int MAX_STATES      = 32;
  localparam int MAX_TRANSITIONS = 64;

  // table addressing, count holds 0 .. MAX_TRANSITIONS
  localparam int TBL_AW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_TRANSITIONS + 1);
  localparam logic [CNT_W-1:0] TBL_DEPTH = CNT_W'(MAX_TRANSITIONS);

  // states that exist, and the largest state count usable on a 32-bit mask
  localparam logic [31:0] STATE_MASK =
    (MAX_STATES >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << MAX_STATES) - 64'd1);
  localparam logic [5:0] STATE_CAP = (MAX_STATES < 32) ? 6'(MAX_STATES) : 6'd32;

  // one transition table entry
  typedef struct packed {
    logic [7:0] label;
    logic [4:0] src;
    logic [4:0] dst;
  } trans_t;

  localparam int TRANS_W = $bits(trans_t);

  // item function codes
  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_START  = 2'd1;
  localparam logic [1:0] FN_FEED   = 2'd2;
  localparam logic [1:0] FN_FINISH = 2'd3;

  // configuration register indexes
  localparam logic REG_NUM_STATES = 1'b0;
  localparam logic REG_EPS_SYMBOL = 1'b1;

endpackage
`default_nettype wire

// File: rtl/epsilon_nfa_acceptor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epsilon_nfa_acceptor_core
// Epsilon-NFA simulator over a byte stream with a loadable transition table.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready is high only while the sequencer is
// idle, and a finished result waits in the output register without holding up
// the next item. Load and start items go straight to the result state. A
// feed item runs closure passes and then one move pass on its symbol, and a
// finish item runs closure passes only; the number of closure passes is at
// least 1 and at most one more than the number of states added. Every pass
// reads each loaded transition once through the single table read port and
// one shared match unit.
// Without a start item, feed and finish work on the set left by the previous
// item; reset leaves only state 0 active and the table empty.
// ----------------------------------------------------------------------------
module epsilon_nfa_acceptor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  symbol,
  input  wire logic [4:0]  from_state,
  input  wire logic [4:0]  to_state,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      active_set,
  output logic             accepted,
  output logic             table_full
);

  import enfa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CLOS = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [5:0] num_states;
  logic [7:0] eps_symbol;

  // automaton state
  logic [31:0]      active_states;
  logic [CNT_W-1:0] trans_count;

  // item and working registers
  logic [1:0]       func_q;
  logic [7:0]       sym_q;
  logic [31:0]      work_set;
  logic [31:0]      acc_set;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld;
  logic             res_acc;
  logic             res_full;

  // table port signals
  logic              tbl_we;
  logic              tbl_re;
  logic [TRANS_W-1:0] tbl_rdata;
  trans_t            tbl_wentry;
  trans_t            rd_entry;

  // datapath helpers
  logic        in_xfer;
  logic        out_free;
  logic        scan_issue;
  logic        pass_end;
  logic [7:0]  match_label;
  logic [31:0] hit_bit;
  logic [31:0] acc_merged;
  logic [31:0] acc_masked;
  logic [5:0]  ns_clamped;
  logic [4:0]  accept_idx;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // transition table
  assign tbl_wentry = '{label: symbol, src: from_state, dst: to_state};
  assign tbl_we     = in_xfer && (func == FN_LOAD) && (trans_count < TBL_DEPTH);
  assign scan_issue = ((state == ST_CLOS) || (state == ST_MOVE)) &&
                      (scan_idx < trans_count);
  assign tbl_re     = scan_issue;

  enfa_ram #(
    .WIDTH (TRANS_W),
    .DEPTH (MAX_TRANSITIONS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (trans_count[TBL_AW-1:0]),
    .wdata (tbl_wentry),
    .re    (tbl_re),
    .raddr (scan_idx[TBL_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // shared match unit: one table entry against the pass's base set
  always_comb begin
    rd_entry    = trans_t'(tbl_rdata);
    match_label = (state == ST_CLOS) ? eps_symbol : sym_q;
    hit_bit     = '0;
    if (rd_vld && (rd_entry.label == match_label) && work_set[rd_entry.src]) begin
      hit_bit[rd_entry.dst] = 1'b1;
    end
    acc_merged = acc_set | hit_bit;
    acc_masked = acc_set & STATE_MASK;
  end

  assign pass_end = (scan_idx == trans_count) && !rd_vld;

  // accepting state index with out-of-range counts clamped
  always_comb begin
    if (num_states == 6'd0) begin
      ns_clamped = 6'd1;
    end else if (num_states > STATE_CAP) begin
      ns_clamped = STATE_CAP;
    end else begin
      ns_clamped = num_states;
    end
    accept_idx = 5'(ns_clamped - 6'd1);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((func == FN_FEED) || (func == FN_FINISH)) begin
            state_next = ST_CLOS;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_CLOS: begin
        if (pass_end && (acc_masked == work_set)) begin
          state_next = (func_q == FN_FEED) ? ST_MOVE : ST_RESP;
        end
      end
      ST_MOVE: begin
        if (pass_end) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= 6'd32;
      eps_symbol <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_STATES: num_states <= cfg_data[5:0];
        REG_EPS_SYMBOL: eps_symbol <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state: table fill, active set, read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      trans_count   <= '0;
      active_states <= 32'd1;
      rd_vld        <= 1'b0;
      scan_idx      <= '0;
    end else begin
      rd_vld <= scan_issue;
      if (scan_issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (tbl_we) begin
        trans_count <= trans_count + CNT_W'(1);
      end
      if (in_xfer) begin
        scan_idx <= '0;
        if (func == FN_START) begin
          active_states <= 32'd1;
        end
      end
      if ((state == ST_CLOS) && pass_end) begin
        scan_idx <= '0;
        if ((acc_masked == work_set) && (func_q == FN_FINISH)) begin
          active_states <= acc_masked;
        end
      end
      if ((state == ST_MOVE) && pass_end) begin
        active_states <= acc_masked;
      end
    end
  end

  // working sets and result fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_q   <= func;
      sym_q    <= symbol;
      work_set <= active_states;
      acc_set  <= active_states;
      res_acc  <= 1'b0;
      res_full <= (func == FN_LOAD) && (trans_count >= TBL_DEPTH);
    end else if (state == ST_CLOS) begin
      if (pass_end) begin
        if (acc_masked != work_set) begin
          // set grew: run another closure pass from the larger set
          work_set <= acc_masked;
          acc_set  <= acc_masked;
        end else if (func_q == FN_FEED) begin
          // closure settled: move pass starts from an empty set
          acc_set <= '0;
        end else begin
          res_acc <= acc_masked[accept_idx];
        end
      end else begin
        acc_set <= acc_merged;
      end
    end else if ((state == ST_MOVE) && !pass_end) begin
      acc_set <= acc_merged;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_RESP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESP) && out_free) begin
      active_set <= active_states;
      accepted   <= res_acc;
      table_full <= res_full;
    end
  end

endmodule
`default_nettype wire

// File: rtl/enfa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enfa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module enfa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
